[design/palette_to_premultiplied_bgra_macros.svh]
// Assertion macros of the palette-to-BGRA design files, used by p2pbgra_fifo.
// Each file that asserts includes this header; it depends on nothing else.
`ifndef PALETTE_TO_PREMULTIPLIED_BGRA_MACROS_SVH
`define PALETTE_TO_PREMULTIPLIED_BGRA_MACROS_SVH
`ifndef NO_ASSERTIONS
`define P2P_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define P2P_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define P2P_ASSERT(lbl, expr, msg)
`define P2P_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[design/p2pbgra_pkg.sv]
// Package of the palette-to-BGRA block: field widths, request and queue codes,
// the queue entry type and the rounded divide by 255. Depends on nothing.
package p2pbgra_pkg;

  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int PROD_W      = 16;
  localparam int DIV_W       = 32;
  localparam int RECIP_SHIFT = 23;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [PROD_W-1:0]  ROUND_HALF  = 16'd127;
  localparam logic [PROD_W-1:0]  RECIP_255   = 16'h8081;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic REG_COLOR_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SKIP   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } q_entry_t;

  // Rounded c*a/255 from the product p; exact for every p up to 255*255.
  function automatic logic [CHAN_W-1:0] div255_round(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] biased;
    logic [DIV_W-1:0]  scaled;
    biased = p + ROUND_HALF;
    scaled = DIV_W'(biased) * DIV_W'(RECIP_255);
    return scaled[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

[design/p2pbgra_front.sv]
// Front end: takes input items, holds the color count register behind the
// APB port and classifies each item into a queue entry. Uses p2pbgra_pkg.
module p2pbgra_front import p2pbgra_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [39:0]            s_tdata,   // pixel_index[7:0], palette_color[39:8]
  input  logic                   s_tuser,   // req_type[0]
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   q_full,
  output logic                   q_push,
  output q_entry_t               q_wdata
);

  localparam logic [COUNT_W-1:0] DEPTH_LIMIT = COUNT_W'(PALETTE_DEPTH);

  logic [COUNT_W-1:0] color_count;
  logic [COUNT_W-1:0] index_ext;
  logic               accept;
  logic               in_table;
  logic               below_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLOR_COUNT) ? 32'(color_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_COLOR_COUNT) begin
      color_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign s_tready    = !q_full;
  assign accept      = s_tvalid && s_tready;
  assign index_ext   = COUNT_W'(s_tdata[INDEX_W-1:0]);
  assign in_table    = index_ext < DEPTH_LIMIT;
  assign below_count = index_ext < color_count;

  always_comb begin
    q_wdata.index = s_tdata[INDEX_W-1:0];
    q_wdata.color = s_tdata[INDEX_W +: COLOR_W];
    if (s_tuser == REQ_WRITE) begin
      q_wdata.op = OP_WRITE;
    end else if (in_table && below_count) begin
      q_wdata.op = OP_LOOKUP;
    end else begin
      q_wdata.op = OP_SKIP;
    end
  end

  // A palette write outside the table is taken and dropped.
  assign q_push = accept && !(s_tuser == REQ_WRITE && !in_table);

endmodule

[design/p2pbgra_fifo.sv]
// Short queue of classified items between the front and back ends.
// Uses p2pbgra_pkg and the assertion macros header.
`include "palette_to_premultiplied_bgra_macros.svh"
module p2pbgra_fifo import p2pbgra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     empty
);

  q_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = count == Q_CNT_W'(Q_DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  `P2P_ASSERT_IMPL(a_no_overflow, push, !full, "item pushed into a full queue")
  `P2P_ASSERT_IMPL(a_no_underflow, pop, !empty, "item popped from an empty queue")
  `P2P_ASSERT(a_count_bound, count <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")
  `P2P_ASSERT_IMPL(a_ptr_match, empty || full, wr_ptr == rd_ptr, "pointers disagree with count")

endmodule

[design/p2pbgra_back.sv]
// Back end: palette memory, lookup, alpha premultiply and the output register.
// Uses p2pbgra_pkg; fed by the queue.
module p2pbgra_back import p2pbgra_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    q_rdata,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
  output logic        m_tuser    // skipped[0]
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [AW-1:0]      addr;
  logic               advance;

  logic               a_valid;
  logic               a_skip;
  logic [COLOR_W-1:0] rd_data;

  logic               b_valid;
  logic               b_skip;
  logic [CHAN_W-1:0]  b_alpha;
  logic [PROD_W-1:0]  b_prod_b;
  logic [PROD_W-1:0]  b_prod_g;
  logic [PROD_W-1:0]  b_prod_r;

  logic [CHAN_W-1:0]  blue_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  alpha_out;
  logic               skipped;

  assign advance = !m_tvalid || m_tready;
  assign q_pop   = advance && !q_empty;
  assign addr    = q_rdata.index[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_rdata.op)
        OP_WRITE:  mem[addr] <= q_rdata.color;
        OP_LOOKUP: rd_data   <= mem[addr];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      a_valid  <= q_pop && (q_rdata.op != OP_WRITE);
      b_valid  <= a_valid;
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_skip   <= q_rdata.op == OP_SKIP;
      b_skip   <= a_skip;
      b_alpha  <= rd_data[24 +: CHAN_W];
      b_prod_b <= PROD_W'(rd_data[0 +: CHAN_W]) * PROD_W'(rd_data[24 +: CHAN_W]);
      b_prod_g <= PROD_W'(rd_data[8 +: CHAN_W]) * PROD_W'(rd_data[24 +: CHAN_W]);
      b_prod_r <= PROD_W'(rd_data[16 +: CHAN_W]) * PROD_W'(rd_data[24 +: CHAN_W]);
      skipped  <= b_skip;
      blue_out  <= b_skip ? '0 : div255_round(b_prod_b);
      green_out <= b_skip ? '0 : div255_round(b_prod_g);
      red_out   <= b_skip ? '0 : div255_round(b_prod_r);
      alpha_out <= b_skip ? '0 : b_alpha;
    end
  end

  assign m_tdata = {alpha_out, red_out, green_out, blue_out};
  assign m_tuser = skipped;

endmodule

[design/palette_to_premultiplied_bgra.sv]
// Top level of the palette-to-premultiplied-BGRA block.
// Connects p2pbgra_front, p2pbgra_fifo and p2pbgra_back; uses p2pbgra_pkg.
//
// Usage: the input stream carries palette writes (tuser 0) and pixels
// (tuser 1). A palette write stores a 32-bit ARGB entry at the index in
// tdata and gives no output item. A pixel gives one output item: BGRA with
// each color multiplied by alpha and rounded, or all zeros with tuser set
// when its index is not below color_count. color_count sits at APB address 0
// and may be written only while the block is idle.
// Throughput is one item per clock in both directions while the output is
// free and the queue is not full. A pixel accepted at the input is written
// into the queue, then goes through registers for the palette memory read,
// the alpha multiply and the divide by 255 before it is presented on the
// output.
// When the receiver stalls, the back pipeline holds and the four-entry queue
// keeps taking items until it is full; then s_tready drops.
// Reset clears the queue, the pipeline and sets color_count to 256; the
// palette contents stay undefined until written.
module palette_to_premultiplied_bgra import p2pbgra_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_index[7:0], palette_color[39:8]
  input  logic        s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
  output logic        m_tuser,   // skipped[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  p2pbgra_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  p2pbgra_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  p2pbgra_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

[tb/bgra_checker.sv]
// Checker for the palette-to-premultiplied-BGRA block: follows palette writes and
// color_count writes, checks color_count reads, predicts each pixel's BGRA output and compares it in order.
// Depends on p2pbgra_pkg for the request and register codes.
`timescale 1ns / 1ps

module bgra_checker import p2pbgra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_index[7:0], palette_color[39:8]
  input  logic        s_tuser,   // req_type[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
  input  logic        m_tuser,   // skipped[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          outstanding,
  output int          fails
);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
    logic              skipped;
  } bgra_t;

  logic [COLOR_W-1:0] palette [256];
  logic [COUNT_W-1:0] color_count = COUNT_RESET;
  bgra_t              expected_pixels [$];
  bgra_t              want;
  bgra_t              got;

  initial begin
    fails = 0;
    outstanding = 0;
    foreach (palette[i]) palette[i] = '0;
  end

  function automatic logic [CHAN_W-1:0] scale_by_alpha(input logic [CHAN_W-1:0] c,
                                                        input logic [CHAN_W-1:0] a);
    int unsigned prod;
    prod = int'(c) * int'(a) + 127;
    return CHAN_W'(prod / 255);
  endfunction

  function automatic bgra_t shade_pixel(input logic [INDEX_W-1:0] idx);
    bgra_t px;
    logic [COLOR_W-1:0] entry;
    px = '0;
    if ({1'b0, idx} >= color_count) begin
      px.skipped = 1'b1;
    end else begin
      entry = palette[idx];
      px.alpha = entry[31:24];
      px.red   = scale_by_alpha(entry[23:16], entry[31:24]);
      px.green = scale_by_alpha(entry[15:8], entry[31:24]);
      px.blue  = scale_by_alpha(entry[7:0], entry[31:24]);
    end
    return px;
  endfunction

  task automatic check_field(input string name, input logic [CHAN_W-1:0] exp_val,
                             input logic [CHAN_W-1:0] act_val);
    if (exp_val !== act_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      color_count = COUNT_RESET;
      expected_pixels.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tuser};
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: unexpected output item, expected none, actual %h/%b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_pixels.pop_front();
          check_field("blue_out", want.blue, got.blue);
          check_field("green_out", want.green, got.green);
          check_field("red_out", want.red, got.red);
          check_field("alpha_out", want.alpha, got.alpha);
          check_field("skipped", CHAN_W'(want.skipped), CHAN_W'(got.skipped));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_WRITE) begin
          palette[s_tdata[7:0]] = s_tdata[39:8];
        end else begin
          expected_pixels = {expected_pixels, shade_pixel(s_tdata[7:0])};
        end
      end
      if (psel && penable && pready && paddr[2] == REG_COLOR_COUNT) begin
        if (pwrite) begin
          color_count = pwdata[COUNT_W-1:0];
        end else if (prdata !== 32'(color_count)) begin
          fails++;
          $display("%0t: color_count read mismatch, expected %h, actual %h",
                   $time, 32'(color_count), prdata);
        end
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

[tb/tb.sv]
// Top of the palette-to-premultiplied-BGRA testbench: clock, reset, APB and stream
// stimulus, and the verdict. Instantiates the block and bgra_checker; uses p2pbgra_pkg.
`timescale 1ns / 1ps

module tb import p2pbgra_pkg::*;;

  localparam logic [2:0] ADDR_COLOR_COUNT = 3'(REG_COLOR_COUNT) << 2;
  localparam logic [2:0] ADDR_NO_REG      = 3'd4;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         PHASE_ITEMS      = 230;
  localparam int         NUM_PHASES       = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = REQ_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          outstanding;
  int          fails;

  bit                 calm = 1'b0;
  bit                 written [256];
  logic [INDEX_W-1:0] filled_idx [$];
  logic [COUNT_W-1:0] cur_count = COUNT_RESET;
  int                 n_writes = 0;
  int                 n_pixels = 0;
  int                 n_settings = 0;

  palette_to_premultiplied_bgra dut (.*);

  bgra_checker u_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 12);
  end

  initial begin
    #2_000_000;
    $display("Run timed out.");
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic typ, input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= typ;
    s_tdata  <= {color, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (typ == REQ_WRITE) begin
      n_writes++;
      if (!written[idx]) filled_idx = {filled_idx, idx};
      written[idx] = 1'b1;
    end else begin
      n_pixels++;
    end
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Palette writes give no output item, so some may still be in flight once the
  // last pixel is out; the drain covers the queue and the pipeline.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input logic [2:0] addr, input logic [31:0] value);
    wait_idle();
    reg_access(1'b1, addr, value);
    @(posedge clk);
    reg_access(1'b0, ADDR_COLOR_COUNT, '0);
    if (addr == ADDR_COLOR_COUNT) cur_count = value[COUNT_W-1:0];
    n_settings++;
  endtask

  task automatic random_item();
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] color;
    logic               typ;
    idx   = INDEX_W'($urandom_range(255));
    color = $urandom;
    case ($urandom_range(3))
      0: color[31:24] = 8'h00;
      1: color[31:24] = 8'hff;
      default: ;
    endcase
    typ = ($urandom_range(3) == 0) ? REQ_WRITE : REQ_PIXEL;
    if (typ == REQ_PIXEL && filled_idx.size() != 0 && $urandom_range(1) == 0) begin
      idx = filled_idx[$urandom_range(filled_idx.size() - 1)];
    end
    // A pixel may not read an entry that was never written.
    if (typ == REQ_PIXEL && !written[idx] && {1'b0, idx} < cur_count) typ = REQ_WRITE;
    send_item(typ, idx, color);
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_count [NUM_PHASES];
    phase_count = '{9'd256, 9'd1, 9'd128, 9'd256, 9'd255, 9'd37};
    phase_count[2] = COUNT_W'($urandom_range(2, 254));
    phase_count[5] = COUNT_W'($urandom_range(1, 256));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(REQ_WRITE, 8'd0, 32'h0000_0000);
    send_item(REQ_WRITE, 8'd255, 32'hffff_ffff);
    send_item(REQ_WRITE, 8'd1, 32'hff00_0000);
    send_item(REQ_WRITE, 8'd2, 32'h00ff_ffff);
    send_item(REQ_WRITE, 8'd3, 32'h80ff_8001);
    send_item(REQ_PIXEL, 8'd0, 32'hffff_ffff);
    send_item(REQ_PIXEL, 8'd255, 32'h0000_0000);
    send_item(REQ_PIXEL, 8'd1, 32'h5a5a_5a5a);
    send_item(REQ_PIXEL, 8'd2, 32'ha5a5_a5a5);
    send_item(REQ_PIXEL, 8'd3, 32'h0000_0000);
    send_item(REQ_WRITE, 8'd4, 32'h7f7f_7f7f);
    send_item(REQ_PIXEL, 8'd4, 32'h0000_0000);
    send_item(REQ_WRITE, 8'd4, 32'h01fe_fdfc);
    send_item(REQ_PIXEL, 8'd4, 32'h0000_0000);

    // Only index 0 is valid with a count of one.
    set_count(ADDR_COLOR_COUNT, 32'd1);
    send_item(REQ_PIXEL, 8'd0, 32'h0000_0000);
    send_item(REQ_PIXEL, 8'd1, 32'h0000_0000);
    send_item(REQ_PIXEL, 8'd255, 32'h0000_0000);
    // A count of zero skips every pixel.
    set_count(ADDR_COLOR_COUNT, 32'd0);
    send_item(REQ_PIXEL, 8'd0, 32'h0000_0000);
    // A count above 256 skips nothing.
    set_count(ADDR_COLOR_COUNT, 32'h0000_01ff);
    send_item(REQ_PIXEL, 8'd255, 32'h0000_0000);
    // A write to an address with no register leaves the count alone.
    set_count(ADDR_NO_REG, 32'd0);
    send_item(REQ_PIXEL, 8'd255, 32'h0000_0000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_count(ADDR_COLOR_COUNT, 32'(phase_count[ph]));
      calm = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end
    calm = 1'b0;

    wait_idle();
    $display("Sent %0d palette writes and %0d pixels across %0d register settings,",
             n_writes, n_pixels, n_settings);
    $display("including skipped pixels, zero and full alpha, and back-to-back overwrites.");
    if (fails == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
